// ===== rtl/sha256_byte_stream_hasher_core_defines.svh =====
// assertion macros for the sha-256 byte stream hasher
// included by rtl files that carry concurrent assertions
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SHBH_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define SHBH_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next cycle check failed");
`else
`define SHBH_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SHBH_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/shbh_pkg.sv =====
// shared types, command codes and sha-256 functions for the byte stream hasher
// no dependencies
package shbh_pkg;

    typedef logic [31:0] word_t;

    localparam logic [1:0] CMD_ABSORB  = 2'd0;
    localparam logic [1:0] CMD_FINISH  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef struct packed {
        logic init;
        logic load;
        logic round;
        logic fold;
    } shbh_ctrl_t;

    typedef struct packed {
        logic       en;
        logic [5:0] addr;
        logic [7:0] data;
    } shbh_wr_t;

    function automatic word_t rotr(input word_t x, input int n);
        return word_t'((x >> n) | (x << (32 - n)));
    endfunction

    function automatic word_t big_sig0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sig1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sig0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sig1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t r;
        case (idx)
            3'd0:    r = 32'h6a09e667;
            3'd1:    r = 32'hbb67ae85;
            3'd2:    r = 32'h3c6ef372;
            3'd3:    r = 32'ha54ff53a;
            3'd4:    r = 32'h510e527f;
            3'd5:    r = 32'h9b05688c;
            3'd6:    r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic word_t round_const(input logic [5:0] idx);
        word_t r;
        case (idx)
            6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;
            default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/sha256_byte_stream_hasher_core.sv =====
// sha-256 byte stream hasher top level: request sequencer, padding and digest output
// depends on shbh_pkg, shbh_sched, shbh_round and the assertion macro header
//
// input channel s_axis: one request per handshake, tuser carries the command
// (absorb byte, finish, restart), tdata carries the message byte
// output channel m_axis: eight digest words after a finish, word 0 first,
// tlast on the eighth word
// an absorb writes one byte; the byte that fills a block adds 64 rounds of the
// shared round unit and then a fold into the chaining words
// a finish pads one byte per cycle up to the block end, then 64 rounds and a
// fold; with more than 55 bytes buffered this repeats for a second block
// digest words go one per cycle unless stalled; a repeated finish emits them at once
// s_axis_tready is high only while the sequencer is idle
// reset (or a restart request) loads the initial hash values and clears the
// byte count, the block count and the finished mark
// a stalled receiver holds the current word on m_axis; nothing is accepted
// until all eight words are taken
module sha256_byte_stream_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast    // last_word
);
    import shbh_pkg::*;

    `include "sha256_byte_stream_hasher_core_defines.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_COMP = 3'd2;
    localparam logic [2:0] ST_FOLD = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [54:0] blocks_reg, blocks_next;
    logic        fin_reg, fin_next;
    logic        pad_reg, pad_next;
    logic        two_blk_reg, two_blk_next;
    logic [6:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;

    logic        s_fire;
    shbh_ctrl_t  ctrl;
    shbh_wr_t    wr;
    word_t       w_cur;
    word_t [7:0] chain_value;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {5'b00000, idx_reg, chain_value[idx_reg]};
    assign m_axis_tlast  = (idx_reg == 3'd7);

    shbh_sched u_sched (
        .clk   (clk),
        .ctrl  (ctrl),
        .wr    (wr),
        .w_cur (w_cur)
    );

    shbh_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .w_cur       (w_cur),
        .rnd         (rnd_reg),
        .chain_value (chain_value)
    );

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        blocks_next  = blocks_reg;
        fin_next     = fin_reg;
        pad_next     = pad_reg;
        two_blk_next = two_blk_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        rnd_next     = rnd_reg;
        idx_next     = idx_reg;
        ctrl         = '0;
        wr           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    case (s_axis_tuser)
                        CMD_ABSORB:
                        begin
                            if (!fin_reg)
                            begin
                                wr.en     = 1'b1;
                                wr.addr   = fill_reg;
                                wr.data   = s_axis_tdata;
                                fill_next = fill_reg + 6'd1;
                                if (fill_reg == 6'd63)
                                begin
                                    ctrl.load   = 1'b1;
                                    rnd_next    = '0;
                                    blocks_next = blocks_reg + 55'd1;
                                    pad_next    = 1'b0;
                                    state_next  = ST_COMP;
                                end
                            end
                        end
                        CMD_FINISH:
                        begin
                            idx_next = '0;
                            if (fin_reg)
                            begin
                                state_next = ST_OUT;
                            end
                            else
                            begin
                                wr.en        = 1'b1;
                                wr.addr      = fill_reg;
                                wr.data      = PAD_MARK;
                                len_next     = {blocks_reg, fill_reg, 3'b000};
                                pos_next     = {1'b0, fill_reg} + 7'd1;
                                two_blk_next = (fill_reg[5:3] == 3'b111);
                                pad_next     = 1'b1;
                                fill_next    = '0;
                                state_next   = ST_PAD;
                            end
                        end
                        CMD_RESTART:
                        begin
                            ctrl.init   = 1'b1;
                            fill_next   = '0;
                            blocks_next = '0;
                            fin_next    = 1'b0;
                            pad_next    = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PAD:
            begin
                if (pos_reg == 7'd64)
                begin
                    ctrl.load  = 1'b1;
                    rnd_next   = '0;
                    state_next = ST_COMP;
                end
                else
                begin
                    wr.en   = 1'b1;
                    wr.addr = pos_reg[5:0];
                    // length bytes only in the final block, most significant first
                    if (pos_reg[5:3] == 3'b111 && !two_blk_reg)
                    begin
                        wr.data  = len_reg[63:56];
                        len_next = {len_reg[55:0], 8'h00};
                    end
                    else
                    begin
                        wr.data = 8'h00;
                    end
                    pos_next = pos_reg + 7'd1;
                end
            end
            ST_COMP:
            begin
                ctrl.round = 1'b1;
                rnd_next   = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                ctrl.fold = 1'b1;
                if (pad_reg)
                begin
                    if (two_blk_reg)
                    begin
                        two_blk_next = 1'b0;
                        pos_next     = '0;
                        state_next   = ST_PAD;
                    end
                    else
                    begin
                        fin_next   = 1'b1;
                        pad_next   = 1'b0;
                        idx_next   = '0;
                        state_next = ST_OUT;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            blocks_reg  <= '0;
            fin_reg     <= 1'b0;
            pad_reg     <= 1'b0;
            two_blk_reg <= 1'b0;
            pos_reg     <= '0;
            rnd_reg     <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            blocks_reg  <= blocks_next;
            fin_reg     <= fin_next;
            pad_reg     <= pad_next;
            two_blk_reg <= two_blk_next;
            pos_reg     <= pos_next;
            rnd_reg     <= rnd_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

    `SHBH_ASSERT_IMP(a_ready_excludes_output, clk, rst_n, s_axis_tready, !m_axis_tvalid)
    `SHBH_ASSERT_NXT(a_last_word_returns_idle, clk, rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)
    `SHBH_ASSERT_NXT(a_rounds_end_in_fold, clk, rst_n, state_reg == ST_COMP && rnd_reg == 6'd63, state_reg == ST_FOLD)
    `SHBH_ASSERT_IMP(a_pad_pos_in_block, clk, rst_n, state_reg == ST_PAD, pos_reg <= 7'd64)
    `SHBH_ASSERT_NXT(a_restart_clears, clk, rst_n, s_fire && s_axis_tuser == CMD_RESTART, fill_reg == 6'd0 && !fin_reg)

endmodule

// ===== rtl/shbh_sched.sv =====
// block buffer and message schedule window, sixteen words shifted once per round
// depends on shbh_pkg
module shbh_sched (
    input  logic               clk,
    input  shbh_pkg::shbh_ctrl_t ctrl,
    input  shbh_pkg::shbh_wr_t   wr,
    output shbh_pkg::word_t      w_cur
);
    import shbh_pkg::*;

    word_t win_reg [16];
    word_t w_new;

    always_comb
    begin
        w_new = small_sig1(win_reg[14]) + win_reg[9] + small_sig0(win_reg[1]) + win_reg[0];
    end

    assign w_cur = win_reg[0];

    always_ff @(posedge clk)
    begin
        if (ctrl.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_new;
        end
        else if (wr.en)
        begin
            // first byte of a word lands in its top lane
            win_reg[wr.addr[5:2]][{~wr.addr[1:0], 3'b000} +: 8] <= wr.data;
        end
    end

endmodule

// ===== rtl/shbh_round.sv =====
// shared compression round unit with working variables and chaining words
// depends on shbh_pkg
module shbh_round (
    input  logic                 clk,
    input  logic                 rst_n,
    input  shbh_pkg::shbh_ctrl_t ctrl,
    input  shbh_pkg::word_t      w_cur,
    input  logic [5:0]           rnd,
    output shbh_pkg::word_t [7:0] chain_value
);
    import shbh_pkg::*;

    word_t [7:0] v_reg;
    word_t [7:0] chain_reg;
    word_t       t1;
    word_t       t2;
    word_t       chv;
    word_t       mj;

    always_comb
    begin
        chv = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        mj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + big_sig1(v_reg[4]) + chv + round_const(rnd) + w_cur;
        t2  = big_sig0(v_reg[0]) + mj;
    end

    assign chain_value = chain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= init_hash(3'(i));
            end
        end
        else if (ctrl.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= init_hash(3'(i));
            end
        end
        else if (ctrl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            v_reg <= chain_reg;
        end
        else if (ctrl.round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule
